// File: src/event_time_priority_table_assert.svh
// assertion macros for the event time priority table rtl
`ifndef EVENT_TIME_PRIORITY_TABLE_ASSERT_SVH
`define EVENT_TIME_PRIORITY_TABLE_ASSERT_SVH

// condition must never hold outside reset
`define ETPT_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ETPT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ETPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/etpt_pkg.sv
// package with payload types, codes and default sizes of the event time priority table
package etpt_pkg;

	localparam int ETPT_QUEUE_DEPTH   = 64;
	localparam int ETPT_TIME_BITS     = 32;
	localparam int ETPT_ELEVATOR_BITS = 4;

	localparam logic [2:0] OP_PUSH   = 3'd0;
	localparam logic [2:0] OP_PEEK   = 3'd1;
	localparam logic [2:0] OP_POP    = 3'd2;
	localparam logic [2:0] OP_FIND   = 3'd3;
	localparam logic [2:0] OP_DELETE = 3'd4;
	localparam logic [2:0] OP_SHIFT  = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] event_time;
		logic [31:0] event_id;
		logic [3:0]  elevator;
		logic [31:0] event_payload;
		logic [31:0] time_increment;
		logic [31:0] time_limit;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_time;
		logic [31:0] found_id;
		logic [3:0]  found_elevator;
		logic [31:0] found_payload;
		logic [6:0]  entry_count;
		logic        is_empty;
	} rsp_t;

endpackage

// File: src/etpt_ram.sv
// generic simple dual port ram with one write port and a registered read port
module etpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/etpt_engine.sv
// sweep sequencer: scans the slot ram for min, id match, free slot or shift, then rank repair
`include "event_time_priority_table_assert.svh"

module etpt_engine import etpt_pkg::*; #(
	parameter int QUEUE_DEPTH   = ETPT_QUEUE_DEPTH,
	parameter int TIME_BITS     = ETPT_TIME_BITS,
	parameter int ELEVATOR_BITS = ETPT_ELEVATOR_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic done_valid,
	input  logic done_ready,
	output rsp_t done_data
);

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int EW   = 1 + TIME_BITS + 32 + ELEVATOR_BITS + 32 + AW;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_FIX    = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]    state_q;
	logic [AW-1:0] addr_q;
	logic          issue_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          rd_last_s1;
	logic [CW-1:0] held_q;
	logic          best_found_q;
	logic          free_found_q;
	logic [AW-1:0] free_addr_q;

	req_t                     req_q;
	logic [1:0]               status_q;
	logic                     emit_q;
	logic [AW-1:0]            best_addr_q;
	logic [TIME_BITS-1:0]     best_time_q;
	logic [AW-1:0]            best_order_q;
	logic [31:0]              best_id_q;
	logic [ELEVATOR_BITS-1:0] best_elev_q;
	logic [31:0]              best_pay_q;

	// ram ports and the unpacked read entry
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [EW-1:0]            ram_wdata;
	logic                     ram_re;
	logic [EW-1:0]            ram_rdata;
	logic                     rd_valid;
	logic [TIME_BITS-1:0]     rd_time;
	logic [31:0]              rd_id;
	logic [ELEVATOR_BITS-1:0] rd_elev;
	logic [31:0]              rd_pay;
	logic [AW-1:0]            rd_order;

	logic [2:0]               op_q;
	logic [TIME_BITS-1:0]     t_n;
	logic [ELEVATOR_BITS-1:0] el_n;
	logic [TIME_BITS-1:0]     inc_n;
	logic [CMPW-1:0]          lim_x;
	logic [TIME_BITS:0]       shift_sum;
	logic [TIME_BITS-1:0]     shift_time;
	logic                     addr_last;
	logic                     take_best;
	logic                     take_free;
	logic                     best_ok;
	logic                     free_ok;
	logic                     shift_hit;
	logic [2:0]               start_state;
	logic [1:0]               start_status;
	logic [2:0]               scan_next;
	logic [1:0]               scan_status;
	logic                     scan_emit;

	etpt_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	assign {rd_valid, rd_time, rd_id, rd_elev, rd_pay, rd_order} = ram_rdata;

	assign op_q  = req_q.operation;
	assign t_n   = TIME_BITS'(req_q.event_time);
	assign el_n  = ELEVATOR_BITS'(req_q.elevator);
	assign inc_n = TIME_BITS'(req_q.time_increment);
	assign lim_x = CMPW'(req_q.time_limit);

	assign addr_last = (addr_q == AW'(QUEUE_DEPTH - 1));
	assign ram_re    = issue_q && (state_q == S_SCAN || state_q == S_FIX);
	assign req_ready = (state_q == S_IDLE);

	// saturating add for shift
	assign shift_sum  = {1'b0, rd_time} + {1'b0, inc_n};
	assign shift_time = shift_sum[TIME_BITS] ? '1 : shift_sum[TIME_BITS-1:0];
	assign shift_hit  = rd_valid && (rd_elev == el_n) && (CMPW'(rd_time) > lim_x);

	always_comb begin
		take_best = 1'b0;
		take_free = 1'b0;
		if (state_q == S_SCAN && rd_vld_s1) begin
			case (op_q)
				OP_PUSH: begin
					take_free = !rd_valid && !free_found_q;
				end
				OP_PEEK, OP_POP: begin
					take_best = rd_valid && (!best_found_q || rd_time < best_time_q ||
						(rd_time == best_time_q && rd_order < best_order_q));
				end
				OP_FIND, OP_DELETE: begin
					take_best = rd_valid && (rd_id == req_q.event_id) &&
						(!best_found_q || rd_order < best_order_q);
				end
				default: begin
					take_best = 1'b0;
				end
			endcase
		end
	end

	assign best_ok = best_found_q || take_best;
	assign free_ok = free_found_q || take_free;

	// where a new request goes first
	always_comb begin
		start_state  = S_DONE;
		start_status = ST_OK;
		case (req_data.operation)
			OP_PUSH: begin
				if (held_q >= CW'(QUEUE_DEPTH)) begin
					start_status = ST_FULL;
				end else begin
					start_state = S_SCAN;
				end
			end
			OP_PEEK, OP_POP, OP_FIND, OP_DELETE: begin
				if (held_q == '0) begin
					start_status = ST_EMPTY;
				end else begin
					start_state = S_SCAN;
				end
			end
			OP_SHIFT: begin
				start_state = S_SCAN;
			end
			default: begin
				start_state = S_DONE;
			end
		endcase
	end

	// outcome at the end of the scan sweep
	always_comb begin
		scan_next   = S_DONE;
		scan_status = ST_OK;
		scan_emit   = 1'b0;
		case (op_q)
			OP_PUSH: begin
				if (free_ok) begin
					scan_next = S_COMMIT;
				end else begin
					scan_status = ST_FULL;
				end
			end
			OP_PEEK, OP_FIND: begin
				scan_emit = best_ok;
				if (!best_ok) begin
					scan_status = (op_q == OP_PEEK) ? ST_EMPTY : ST_NOT_FOUND;
				end
			end
			OP_POP, OP_DELETE: begin
				scan_emit = best_ok;
				if (best_ok) begin
					scan_next = S_FIX;
				end else begin
					scan_status = (op_q == OP_POP) ? ST_EMPTY : ST_NOT_FOUND;
				end
			end
			default: begin
				scan_next = S_DONE;
			end
		endcase
	end

	// write port: clearing pass, shift write-back, rank repair, push
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = ram_rdata;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				ram_wdata = '0;
			end
			S_SCAN: begin
				if (rd_vld_s1 && op_q == OP_SHIFT && shift_hit) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b1, shift_time, rd_id, rd_elev, rd_pay, rd_order};
				end
			end
			S_FIX: begin
				if (rd_vld_s1) begin
					if (rd_addr_s1 == best_addr_q) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b0, rd_time, rd_id, rd_elev, rd_pay, rd_order};
					end else if (rd_valid && rd_order > best_order_q) begin
						ram_we    = 1'b1;
						ram_wdata = {1'b1, rd_time, rd_id, rd_elev, rd_pay,
							rd_order - AW'(1)};
					end
				end
			end
			S_COMMIT: begin
				ram_we    = 1'b1;
				ram_waddr = free_addr_q;
				ram_wdata = {1'b1, t_n, req_q.event_id, el_n, req_q.event_payload,
					AW'(held_q)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			issue_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			held_q       <= '0;
			best_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (ram_re) begin
				addr_q <= addr_last ? '0 : addr_q + AW'(1);
				if (addr_last) begin
					issue_q <= 1'b0;
				end
			end
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_last ? '0 : addr_q + AW'(1);
					if (addr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						best_found_q <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= start_state;
						issue_q      <= (start_state == S_SCAN);
					end
				end
				S_SCAN: begin
					if (rd_vld_s1) begin
						if (take_free) begin
							free_found_q <= 1'b1;
						end
						if (take_best) begin
							best_found_q <= 1'b1;
						end
						if (rd_last_s1) begin
							state_q <= scan_next;
							issue_q <= (scan_next == S_FIX);
						end
					end
				end
				S_FIX: begin
					if (rd_vld_s1 && rd_last_s1) begin
						held_q  <= held_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_COMMIT: begin
					held_q  <= held_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (done_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q;
		rd_last_s1 <= addr_last;
		if (state_q == S_IDLE && req_valid) begin
			req_q    <= req_data;
			status_q <= start_status;
			emit_q   <= 1'b0;
		end
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (take_best) begin
				best_addr_q  <= rd_addr_s1;
				best_time_q  <= rd_time;
				best_order_q <= rd_order;
				best_id_q    <= rd_id;
				best_elev_q  <= rd_elev;
				best_pay_q   <= rd_pay;
			end
			if (take_free) begin
				free_addr_q <= rd_addr_s1;
			end
			if (rd_last_s1) begin
				status_q <= scan_status;
				emit_q   <= scan_emit;
			end
		end
		if (state_q == S_COMMIT) begin
			// echo the pushed event
			best_time_q <= t_n;
			best_id_q   <= req_q.event_id;
			best_elev_q <= el_n;
			best_pay_q  <= req_q.event_payload;
			status_q    <= ST_OK;
			emit_q      <= 1'b1;
		end
	end

	assign done_valid = (state_q == S_DONE);

	always_comb begin
		done_data                = '0;
		done_data.status         = status_q;
		done_data.entry_count    = 7'(held_q);
		done_data.is_empty       = (held_q == '0);
		if (emit_q) begin
			done_data.found_time     = 32'(best_time_q);
			done_data.found_id       = best_id_q;
			done_data.found_elevator = 4'(best_elev_q);
			done_data.found_payload  = best_pay_q;
		end
	end

	`ETPT_ASSERT_NEVER(a_no_rw_same_slot, ram_re && ram_we && (ram_waddr == addr_q),
		"slot read and written in the same cycle")
	`ETPT_ASSERT_NEVER(a_count_in_range, held_q > CW'(QUEUE_DEPTH),
		"held count above queue depth")
	`ETPT_ASSERT_IMPL(a_commit_has_slot, state_q == S_COMMIT, free_found_q,
		"push committed without a free slot")
	`ETPT_ASSERT_NEXT(a_done_to_idle, done_valid && done_ready, state_q == S_IDLE,
		"sequencer did not return to idle after result")

endmodule

// File: src/event_time_priority_table.sv
// top level of the event time priority table: request intake and result register
//
//  channel | signals                       | payload
//  --------+-------------------------------+--------
//  request | req_valid, req_ready          | req_data (req_t)
//  result  | rsp_valid, rsp_ready          | rsp_data (rsp_t)
//
// one request at a time; every request that needs the table sweeps the slot ram once,
// push adds a commit state, and pop or delete with a hit add a rank repair sweep;
// requests that need no sweep go straight to the done state.
// after reset a clearing pass over every slot runs before req_ready rises.
// a finished result waits in the result register while the next request is taken.
module event_time_priority_table import etpt_pkg::*; #(
	parameter int QUEUE_DEPTH   = ETPT_QUEUE_DEPTH,
	parameter int TIME_BITS     = ETPT_TIME_BITS,
	parameter int ELEVATOR_BITS = ETPT_ELEVATOR_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	logic eng_valid;
	logic eng_ready;
	rsp_t eng_data;
	logic rsp_valid_q;
	rsp_t rsp_q;

	etpt_engine #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.TIME_BITS     (TIME_BITS),
		.ELEVATOR_BITS (ELEVATOR_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.done_valid (eng_valid),
		.done_ready (eng_ready),
		.done_data  (eng_data)
	);

	// result register frees up in the cycle it is taken
	assign eng_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_ready) begin
			rsp_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_valid && eng_ready) begin
			rsp_q <= eng_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
